/* rtl/b64se_pkg.sv */
// Shared types, constants and alphabet lookup for the base64 stream encoder.
package b64se_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;

    // One accepted byte, fully resolved into its characters.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last;
        logic            final_flag;
    } b64se_job_t;

    typedef struct packed {
        logic       valid;
        b64se_job_t job;
    } b64se_push_t;

    typedef struct packed {
        logic       valid;
        b64se_job_t job;
    } b64se_pop_t;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] wide;
        wide = {2'b00, idx};
        if (idx < 6'd26)
            return wide + CHAR_UPPER;
        else if (idx < 6'd52)
            return wide + (CHAR_LOWER - 8'd26);
        else if (idx < 6'd62)
            return wide - (8'd52 - CHAR_DIGIT);
        else if (idx == 6'd62)
            return CHAR_PLUS;
        else
            return CHAR_SLASH;
    endfunction

endpackage

/* rtl/b64se_in_if.sv */
// Input channel: one raw byte per transaction with its end-of-message flag.
interface b64se_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

/* rtl/b64se_out_if.sv */
// Output channel: one encoded character per transaction with end markers.
interface b64se_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_end;
    logic       message_end;

    modport source (output valid, output out_char, output run_end, output message_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_end, input message_end,
                    output ready);
endinterface

/* rtl/base64_stream_encoder.sv */
// Top level of the streaming base64 encoder.
// Encodes a byte stream into standard base64 (A-Z a-z 0-9 + /) with '=' padding, one
// message after another; final_byte marks the last byte of each message. Each byte
// yields one or two characters, and a final byte also yields the zero-filled tail
// character and padding, up to four characters in all. The front end takes a byte in
// every cycle while its two-entry job queue has room; the emitter puts out at most one
// character per cycle, so sustained throughput is set by the output port: four
// characters per three bytes, plus tail and padding at message end. A byte's first
// character is offered once its job has moved from the queue into the job register.
// run_end flags the last character of each byte; message_end the last of a message.
module base64_stream_encoder (
    input  logic        clk,
    input  logic        rst_n,
    b64se_in_if.sink    byte_ch,
    b64se_out_if.source char_ch
);
    import b64se_pkg::*;

    b64se_push_t push;
    b64se_pop_t  pop;
    logic        push_ready;
    logic        pop_ready;

    b64se_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .push       (push),
        .push_ready (push_ready)
    );

    b64se_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    b64se_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_ready (pop_ready),
        .char_ch   (char_ch)
    );

endmodule

/* rtl/b64se_front.sv */
// Front end: accepts bytes, tracks leftover bits and phase, builds character jobs.
module b64se_front (
    input  logic               clk,
    input  logic               rst_n,
    b64se_in_if.sink           byte_ch,
    output b64se_pkg::b64se_push_t push,
    input  logic               push_ready
);
    import b64se_pkg::*;

    localparam logic [2:0] CNT_NONE = 3'd0;
    localparam logic [2:0] CNT_TWO  = 3'd2;
    localparam logic [2:0] CNT_FOUR = 3'd4;

    logic [3:0] left_reg,  left_next;
    logic [2:0] cnt_reg,   cnt_next;
    logic [1:0] phase_reg, phase_next;

    logic [5:0] idx0, idx1, tail_idx;
    logic       two_main;
    logic [3:0] new_left;
    logic [2:0] new_cnt;
    logic [1:0] phase_main, phase_tail, pads;
    logic       tail;
    logic [2:0] n_main_tail, total;
    logic       accept;

    assign byte_ch.ready = push_ready;
    assign accept        = byte_ch.valid && push_ready;

    always_comb
    begin
        idx1     = 6'd0;
        two_main = 1'b0;
        unique case (cnt_reg)
            CNT_NONE:
            begin
                idx0     = byte_ch.data_byte[7:2];
                new_left = {2'b00, byte_ch.data_byte[1:0]};
                new_cnt  = CNT_TWO;
            end
            CNT_TWO:
            begin
                idx0     = {left_reg[1:0], byte_ch.data_byte[7:4]};
                new_left = byte_ch.data_byte[3:0];
                new_cnt  = CNT_FOUR;
            end
            default:
            begin
                idx0     = {left_reg[3:0], byte_ch.data_byte[7:6]};
                idx1     = byte_ch.data_byte[5:0];
                two_main = 1'b1;
                new_left = 4'd0;
                new_cnt  = CNT_NONE;
            end
        endcase

        phase_main = phase_reg + (two_main ? 2'd2 : 2'd1);
        tail       = byte_ch.final_byte && (new_cnt != CNT_NONE);
        tail_idx   = (new_cnt == CNT_TWO) ? {new_left[1:0], 4'b0000}
                                          : {new_left[3:0], 2'b00};
        phase_tail = phase_main + {1'b0, tail};
        // pad up to a multiple of four characters
        pads       = byte_ch.final_byte ? (2'd0 - phase_tail) : 2'd0;

        n_main_tail = (two_main ? 3'd2 : 3'd1) + {2'b00, tail};
        total       = n_main_tail + {1'b0, pads};
        if (total > 3'd4)
            total = 3'd4;

        push.valid          = byte_ch.valid;
        push.job.final_flag = byte_ch.final_byte;
        push.job.last       = 2'(total - 3'd1);
        push.job.chars[0]   = b64_char(idx0);
        push.job.chars[1]   = two_main ? b64_char(idx1)
                            : (tail ? b64_char(tail_idx) : CHAR_PAD);
        push.job.chars[2]   = (two_main && tail) ? b64_char(tail_idx) : CHAR_PAD;
        push.job.chars[3]   = CHAR_PAD;

        left_next  = left_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            if (byte_ch.final_byte)
            begin
                left_next  = 4'd0;
                cnt_next   = CNT_NONE;
                phase_next = 2'd0;
            end
            else
            begin
                left_next  = new_left;
                cnt_next   = new_cnt;
                phase_next = phase_main;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= 4'd0;
            cnt_reg   <= CNT_NONE;
            phase_reg <= 2'd0;
        end
        else
        begin
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    // leftover count and character phase move in lockstep
    a_phase_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CNT_NONE && phase_reg == 2'd0) ||
        (cnt_reg == CNT_TWO  && phase_reg == 2'd1) ||
        (cnt_reg == CNT_FOUR && phase_reg == 2'd2))
        else $error("leftover count and phase out of step");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_ch.final_byte |=> cnt_reg == CNT_NONE && phase_reg == 2'd0)
        else $error("state not cleared after final byte");

endmodule

/* rtl/b64se_queue.sv */
// Two-entry job queue between the front end and the character emitter.
module b64se_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  b64se_pkg::b64se_push_t push,
    output logic                   push_ready,
    output b64se_pkg::b64se_pop_t  pop,
    input  logic                   pop_ready
);
    import b64se_pkg::*;

    b64se_job_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg,  count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop.valid  = (count_reg != '0);
    assign pop.job    = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy overflow");

endmodule

/* rtl/b64se_back.sv */
// Back end: steps through each job's characters, one output transaction per cycle while the output is ready.
module b64se_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64se_pkg::b64se_pop_t pop,
    output logic                  pop_ready,
    b64se_out_if.source           char_ch
);
    import b64se_pkg::*;

    b64se_job_t job_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg,  idx_next;
    logic       at_last;

    assign at_last   = (idx_reg == job_reg.last);
    assign pop_ready = !busy_reg || (char_ch.ready && at_last);

    assign char_ch.valid       = busy_reg;
    assign char_ch.out_char    = job_reg.chars[idx_reg];
    assign char_ch.run_end     = at_last;
    assign char_ch.message_end = at_last && job_reg.final_flag;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop_ready)
        begin
            busy_next = pop.valid;
            idx_next  = 2'd0;
        end
        else if (char_ch.ready)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop.valid)
            job_reg <= pop.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= job_reg.last)
        else $error("character index past end of job");

    a_step_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && char_ch.ready && !at_last |=> busy_reg && idx_reg == $past(idx_reg) + 2'd1)
        else $error("emitter skipped or repeated a character");

endmodule
